FILE: rtl/eh_frame_fde_counter_defines.svh
// Assertion macros for the exception-frame record walker.
`ifndef EH_FRAME_FDE_COUNTER_DEFINES_SVH
`define EH_FRAME_FDE_COUNTER_DEFINES_SVH

// Same-cycle implication, checked on the rising clock, off in reset.
`define EFC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("efc assertion failed");

// Next-cycle implication, checked on the rising clock, off in reset.
`define EFC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("efc assertion failed");

`endif

FILE: rtl/efc_pkg.sv
package efc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POS_W    = 2;
    localparam int unsigned M_DATA_W = 40;

    localparam logic [WORD_W-1:0] LEN_ESCAPE = 32'hffff_ffff;
    localparam logic [WORD_W-1:0] ID_BYTES   = 32'd4;
    localparam logic [WORD_W-1:0] COUNT_MAX  = 32'hffff_ffff;
    localparam logic [POS_W-1:0]  POS_LAST   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_CLEAN  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ESCAPE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd3;

    typedef enum logic [3:0] {
        PH_LEN  = 4'b0001,
        PH_ID   = 4'b0010,
        PH_BODY = 4'b0100,
        PH_STOP = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [STATUS_W-1:0] end_status;
        logic [WORD_W-1:0]   fde_count;
    } result_t;

endpackage

FILE: rtl/eh_frame_fde_counter.sv
// Exception-frame record walker: counts FDE records in a byte stream.
// Input channel s_*: one section byte per beat in s_tdata[7:0]; s_tlast on
// the final byte of a section. Records are a little-endian 32-bit length,
// then a 32-bit id; a nonzero id counts as one FDE, the rest is skipped.
// Result channel m_*: one beat per section, issued for the s_tlast beat:
// fde_count (saturating) and end_status (0 clean, 1 64-bit length escape,
// 2 length of 1 to 3).
// Throughput: one byte per cycle, sustained while no s_tlast beat waits on
// the result slot. An accepted beat is registered in the input stage, then
// processed by the walker, and its result is registered onto m_tvalid/m_tdata.
// The record walk is a single update of the state registers per byte.
// Stall: a result waiting on m_tready blocks only the next s_tlast beat;
// ordinary bytes keep flowing. After each section all walk state returns to
// its reset value. Reset (aresetn low, synchronous) empties both stages and
// clears the walk; s_tready is held low while aresetn is low.
`include "eh_frame_fde_counter_defines.svh"

module eh_frame_fde_counter
    import efc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic                s_tlast,   // last_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [31:0] fde_count, [33:32] end_status
);

    logic              step;
    logic              out_free;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    logic              res_valid;
    result_t           res;

    efc_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .s_last   (s_tlast),
        .out_free (out_free),
        .step     (step),
        .in_byte  (in_byte),
        .in_last  (in_last)
    );

    efc_walker u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_byte),
        .last_byte (in_last),
        .res_valid (res_valid),
        .res       (res)
    );

    efc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `EFC_ASSERT_NOW(a_no_overwrite, aclk, aresetn, res_valid, out_free)
    `EFC_ASSERT_NEXT(a_last_gives_beat, aclk, aresetn, step && in_last, m_tvalid)
    `EFC_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid, m_tdata[33:32] != ST_NONE)
    `EFC_ASSERT_NOW(a_stall_holds_item, aclk, aresetn, !s_tready, !step)

endmodule

FILE: rtl/efc_in_stage.sv
module efc_in_stage
    import efc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_byte,
    input  logic              s_last,
    input  logic              out_free,
    output logic              step,
    output logic [BYTE_W-1:0] in_byte,
    output logic              in_last
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    // a last beat needs the result slot; other beats never wait
    assign step     = valid_reg && (!last_reg || out_free);
    assign s_tready = aresetn && (!valid_reg || step);

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (step) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_byte;
            last_reg <= s_last;
        end
    end

    assign in_byte = byte_reg;
    assign in_last = last_reg;

endmodule

FILE: rtl/efc_walker.sv
module efc_walker
    import efc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_byte,
    output logic              res_valid,
    output result_t           res
);

    phase_t              phase_reg,  phase_next;
    logic [POS_W-1:0]    pos_reg,    pos_next;
    logic [WORD_W-1:0]   len_reg,    len_next;
    logic                id_nz_reg,  id_nz_next;
    logic [WORD_W-1:0]   body_reg,   body_next;
    logic [WORD_W-1:0]   count_reg,  count_next;
    logic [STATUS_W-1:0] reason_reg, reason_next;
    logic [WORD_W-1:0]   len_merge;
    logic                id_nz_merge;
    logic                byte_nz;

    assign byte_nz     = (data_byte != '0);
    assign id_nz_merge = id_nz_reg || byte_nz;

    always_comb begin
        len_merge = len_reg;
        len_merge[{pos_reg, 3'b000} +: BYTE_W] = data_byte;
    end

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        id_nz_next  = id_nz_reg;
        body_next   = body_reg;
        count_next  = count_reg;
        reason_next = reason_reg;
        if (step) begin
            unique case (phase_reg)
                PH_LEN: begin
                    len_next = len_merge;
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == POS_LAST) begin
                        if (len_merge == '0) begin
                            phase_next = PH_LEN;
                        end else if (len_merge == LEN_ESCAPE) begin
                            phase_next  = PH_STOP;
                            reason_next = ST_ESCAPE;
                        end else if (len_merge < ID_BYTES) begin
                            phase_next  = PH_STOP;
                            reason_next = ST_SHORT;
                        end else begin
                            body_next  = len_merge - ID_BYTES;
                            id_nz_next = 1'b0;
                            phase_next = PH_ID;
                        end
                    end
                end
                PH_ID: begin
                    id_nz_next = id_nz_merge;
                    pos_next   = pos_reg + 1'b1;
                    if (pos_reg == POS_LAST) begin
                        if (id_nz_merge && count_reg != COUNT_MAX) begin
                            count_next = count_reg + 1'b1;
                        end
                        phase_next = (body_reg == '0) ? PH_LEN : PH_BODY;
                    end
                end
                PH_BODY: begin
                    body_next = body_reg - 1'b1;
                    if (body_reg == WORD_W'(1)) begin
                        phase_next = PH_LEN;
                        pos_next   = '0;
                    end
                end
                PH_STOP: begin
                    phase_next = PH_STOP;
                end
                default: begin
                    phase_next = PH_STOP;
                end
            endcase
            // end of section: report, then start over
            if (last_byte) begin
                phase_next  = PH_LEN;
                pos_next    = '0;
                len_next    = '0;
                id_nz_next  = 1'b0;
                body_next   = '0;
                count_next  = '0;
                reason_next = ST_CLEAN;
            end
        end
    end

    always_comb begin
        res_valid      = step && last_byte;
        res.fde_count  = count_reg;
        res.end_status = reason_reg;
        if (step) begin
            unique case (phase_reg)
                PH_ID: begin
                    if (pos_reg == POS_LAST && id_nz_merge && count_reg != COUNT_MAX) begin
                        res.fde_count = count_reg + 1'b1;
                    end
                end
                PH_LEN: begin
                    if (pos_reg == POS_LAST && len_merge == LEN_ESCAPE) begin
                        res.end_status = ST_ESCAPE;
                    end else if (pos_reg == POS_LAST && len_merge != '0
                                 && len_merge < ID_BYTES) begin
                        res.end_status = ST_SHORT;
                    end
                end
                PH_BODY, PH_STOP: begin
                    res.fde_count = count_reg;
                end
                default: begin
                    res.fde_count = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LEN;
            pos_reg    <= '0;
            len_reg    <= '0;
            id_nz_reg  <= 1'b0;
            body_reg   <= '0;
            count_reg  <= '0;
            reason_reg <= ST_CLEAN;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            id_nz_reg  <= id_nz_next;
            body_reg   <= body_next;
            count_reg  <= count_next;
            reason_reg <= reason_next;
        end
    end

endmodule

FILE: rtl/efc_out_stage.sv
module efc_out_stage
    import efc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_valid,
    input  result_t             res,
    output logic                out_free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_DATA_W - WORD_W - STATUS_W){1'b0}},
                       res_reg.end_status, res_reg.fde_count};

endmodule
